// File: design/ldsc_pkg.sv
// Shared types, constants and table builder for the lead-in drift sync clock.
package ldsc_pkg;

  localparam int DECAY_TABLE_BITS_DEF = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [23:0] LEAD_MIN_UNITS = 24'd512000;
  localparam int DIV_STEPS = 34;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEAD_IN   = 3'd0,
    REG_FIRST_OBJ = 3'd1,
    REG_GLOBAL    = 3'd2,
    REG_LOCAL     = 3'd3,
    REG_MAX_FRAME = 3'd4,
    REG_MAX_ERROR = 3'd5,
    REG_HALVING   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

  // Q16 value of 2^-(idx / 2^bits), built with integer square roots.
  function automatic logic [16:0] decay_entry(input int bits, input int idx);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] e;
    s = 64'd1 << 29;
    for (int i = 0; i < bits; i++) begin
      v = s << 30;
      res = 64'd0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 64'd0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      s = res;
    end
    t = 64'd1 << 30;
    for (int j = 1; j <= idx; j++) t = (t * s + (64'd1 << 29)) >> 30;
    e = (t + (64'd1 << 13)) >> 14;
    return e[16:0];
  endfunction

endpackage

// File: design/ldsc_channels.sv
// Channel interfaces: input items, result items and configuration writes.
interface ldsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [17:0] elapsed;
  modport source (output valid, output command, output elapsed, input ready);
  modport sink (input valid, input command, input elapsed, output ready);
endinterface

interface ldsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] clock_time;
  logic               audio_start;
  logic               is_running;
  logic               audio_phase;
  logic [31:0]        audio_elapsed;
  modport source (output valid, output clock_time, output audio_start, output is_running,
                  output audio_phase, output audio_elapsed, input ready);
  modport sink (input valid, input clock_time, input audio_start, input is_running,
                input audio_phase, input audio_elapsed, output ready);
endinterface

interface ldsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ldsc_pkg::CFG_IDX_W-1:0]   index;
  logic [ldsc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/ldsc_ctrl.sv
// Controller state machine sequencing prep, divide, multiply and commit.
module ldsc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ldsc_pkg::ctrl_stat_t   stat,
  output ldsc_pkg::ctrl_cmd_t    cmd
);

  ldsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ldsc_pkg::S_IDLE: begin
        if (in_valid && rst_n) state_nxt = ldsc_pkg::S_PREP;
      end
      ldsc_pkg::S_PREP: begin
        state_nxt = stat.need_div ? ldsc_pkg::S_DIV : ldsc_pkg::S_COMMIT;
      end
      ldsc_pkg::S_DIV: begin
        if (stat.div_done) state_nxt = ldsc_pkg::S_MUL;
      end
      ldsc_pkg::S_MUL: begin
        state_nxt = ldsc_pkg::S_COMMIT;
      end
      ldsc_pkg::S_COMMIT: begin
        if (stat.out_free) state_nxt = ldsc_pkg::S_IDLE;
      end
      default: state_nxt = ldsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ldsc_pkg::S_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      ldsc_pkg::S_PREP:   cmd.prep = 1'b1;
      ldsc_pkg::S_DIV:    cmd.div_step = 1'b1;
      ldsc_pkg::S_MUL:    cmd.mul = 1'b1;
      ldsc_pkg::S_COMMIT: cmd.commit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/ldsc_datapath.sv
// Datapath: config registers, clock state, serial divider, decay multiply, result register.
module ldsc_datapath #(
  parameter int DECAY_TABLE_BITS = ldsc_pkg::DECAY_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ldsc_pkg::ctrl_cmd_t             cmd,
  output ldsc_pkg::ctrl_stat_t            stat,
  input  logic [1:0]                      in_command,
  input  logic [17:0]                     in_elapsed,
  input  logic                            cfg_valid,
  input  logic [ldsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_clock_time,
  output logic                            out_audio_start,
  output logic                            out_is_running,
  output logic                            out_audio_phase,
  output logic [31:0]                     out_audio_elapsed
);

  localparam int TSIZE = 1 << DECAY_TABLE_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'h7fffffff;
    if (v < -40'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Config registers
  logic [23:0]        lead_in_r;
  logic [29:0]        first_obj_r;
  logic signed [20:0] global_off_r;
  logic signed [20:0] local_off_r;
  logic [17:0]        max_frame_r;
  logic [23:0]        max_error_r;
  logic [19:0]        halving_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_in_r      <= '0;
      first_obj_r    <= '0;
      global_off_r   <= '0;
      local_off_r    <= '0;
      max_frame_r    <= 18'd25600;
      max_error_r    <= 24'd51200;
      halving_span_r <= 20'd12800;
    end else if (cfg_valid) begin
      case (cfg_index)
        ldsc_pkg::REG_LEAD_IN:   lead_in_r      <= cfg_data[23:0];
        ldsc_pkg::REG_FIRST_OBJ: first_obj_r    <= cfg_data[29:0];
        ldsc_pkg::REG_GLOBAL:    global_off_r   <= cfg_data[20:0];
        ldsc_pkg::REG_LOCAL:     local_off_r    <= cfg_data[20:0];
        ldsc_pkg::REG_MAX_FRAME: max_frame_r    <= cfg_data[17:0];
        ldsc_pkg::REG_MAX_ERROR: max_error_r    <= cfg_data[23:0];
        ldsc_pkg::REG_HALVING:   halving_span_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Decay table
  logic [16:0] table_w [TSIZE];
  for (genvar gi = 0; gi < TSIZE; gi++) begin : g_tab
    localparam logic [16:0] ENTRY = ldsc_pkg::decay_entry(DECAY_TABLE_BITS, gi);
    assign table_w[gi] = ENTRY;
  end

  // Clock state
  logic               running_r, tracking_r;
  logic signed [31:0] game_r;
  logic [31:0]        wall_r, asw_r;

  // Captured transaction and prep results
  logic [1:0]         cmd_r;
  logic [17:0]        el_r;
  logic [31:0]        wall_n_r;
  logic               g_nonneg_r;
  logic signed [31:0] g_r;
  logic signed [33:0] target_r;
  logic signed [34:0] diff_r;
  logic               snap_r;

  // Prep arithmetic
  logic [17:0]        dt_c;
  logic [32:0]        wall_sum_c;
  logic [31:0]        wall_n_c;
  logic signed [32:0] g_c;
  logic [31:0]        pos_c;
  logic signed [21:0] off_c;
  logic signed [33:0] target_c;
  logic signed [33:0] interp_c;
  logic signed [34:0] diff_c;
  logic [34:0]        err_c;
  logic               snap_c;

  always_comb begin
    dt_c       = (el_r < max_frame_r) ? el_r : max_frame_r;
    wall_sum_c = {1'b0, wall_r} + {15'd0, dt_c};
    wall_n_c   = wall_sum_c[32] ? 32'hffffffff : wall_sum_c[31:0];
    g_c        = {game_r[31], game_r} + $signed({15'd0, dt_c});
    pos_c      = wall_n_c - asw_r;
    off_c      = {global_off_r[20], global_off_r} + {local_off_r[20], local_off_r};
    target_c   = $signed({2'b00, pos_c}) - {{12{off_c[21]}}, off_c};
    interp_c   = {{2{game_r[31]}}, game_r} + $signed({16'd0, dt_c});
    diff_c     = {interp_c[33], interp_c} - {target_c[33], target_c};
    err_c      = diff_c[34] ? 35'(-diff_c) : 35'(diff_c);
    snap_c     = err_c > {11'd0, max_error_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      el_r  <= in_elapsed;
    end
    if (cmd.prep) begin
      wall_n_r   <= wall_n_c;
      g_nonneg_r <= !g_c[32];
      g_r        <= g_c[31:0];
      target_r   <= target_c;
      diff_r     <= diff_c;
      snap_r     <= snap_c;
    end
  end

  // Serial restoring divider: (dt << 16) / halving span, one quotient bit a cycle
  logic [33:0] quo_r;
  logic [19:0] rem_r;
  logic [5:0]  cnt_r;
  logic [20:0] rem_sh;
  logic [20:0] hl_ext;
  logic        q_bit;
  logic [20:0] rem_dif;

  always_comb begin
    hl_ext  = {1'b0, (halving_span_r == 20'd0) ? 20'd1 : halving_span_r};
    rem_sh  = {rem_r, quo_r[33]};
    q_bit   = rem_sh >= hl_ext;
    rem_dif = rem_sh - hl_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r <= {dt_c, 16'd0};
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_dif[19:0] : rem_sh[19:0];
      quo_r <= {quo_r[32:0], q_bit};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  // Decay factor and multiply
  logic [17:0]        n_c;
  logic [DECAY_TABLE_BITS-1:0] idx_c;
  logic [16:0]        factor_c;
  logic signed [52:0] prod_r;

  always_comb begin
    n_c      = quo_r[33:16];
    idx_c    = quo_r[15 -: DECAY_TABLE_BITS];
    factor_c = (n_c >= 18'd32) ? 17'd0 : (table_w[idx_c] >> n_c[4:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= diff_r * $signed({1'b0, factor_c});
  end

  // Commit: next state and result
  logic signed [36:0] shifted_c;
  logic signed [37:0] decay_sum_c;
  logic [24:0]        lead_c;
  logic signed [30:0] st_c;
  logic               run_nxt, track_nxt, pulse_nxt;
  logic signed [31:0] game_nxt;
  logic [31:0]        wall_nxt, asw_nxt;

  always_comb begin
    shifted_c   = 37'(prod_r >>> 16);
    decay_sum_c = {{4{target_r[33]}}, target_r} + {shifted_c[36], shifted_c};
    lead_c      = {1'b0, (lead_in_r > ldsc_pkg::LEAD_MIN_UNITS) ? lead_in_r
                                                                 : ldsc_pkg::LEAD_MIN_UNITS};
    st_c        = $signed({1'b0, first_obj_r}) - $signed({6'd0, lead_c});
    run_nxt   = running_r;
    track_nxt = tracking_r;
    pulse_nxt = 1'b0;
    game_nxt  = game_r;
    wall_nxt  = wall_r;
    asw_nxt   = asw_r;
    case (cmd_r)
      ldsc_pkg::CMD_START: begin
        game_nxt  = st_c[30] ? {st_c[30], st_c} : 32'sd0;
        wall_nxt  = '0;
        track_nxt = 1'b0;
        run_nxt   = 1'b1;
      end
      ldsc_pkg::CMD_STOP: begin
        run_nxt   = 1'b0;
        track_nxt = 1'b0;
      end
      ldsc_pkg::CMD_TICK: begin
        if (running_r) begin
          wall_nxt = wall_n_r;
          if (!tracking_r) begin
            if (g_nonneg_r) begin
              track_nxt = 1'b1;
              asw_nxt   = wall_n_r;
              game_nxt  = 32'sd0;
              pulse_nxt = 1'b1;
            end else begin
              game_nxt = g_r;
            end
          end else if (snap_r) begin
            game_nxt = sat32({{6{target_r[33]}}, target_r});
          end else begin
            game_nxt = sat32({{2{decay_sum_c[37]}}, decay_sum_c});
          end
        end
      end
      default: ;
    endcase
  end

  logic               out_valid_r;
  logic signed [31:0] out_time_r;
  logic               out_pulse_r, out_run_r, out_track_r;
  logic [31:0]        out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      tracking_r  <= 1'b0;
      game_r      <= '0;
      wall_r      <= '0;
      asw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        running_r   <= run_nxt;
        tracking_r  <= track_nxt;
        game_r      <= game_nxt;
        wall_r      <= wall_nxt;
        asw_r       <= asw_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_time_r  <= game_nxt;
      out_pulse_r <= pulse_nxt;
      out_run_r   <= run_nxt;
      out_track_r <= track_nxt;
      out_pos_r   <= track_nxt ? (wall_nxt - asw_nxt) : 32'd0;
    end
  end

  assign stat.need_div = (cmd_r == ldsc_pkg::CMD_TICK) && running_r && tracking_r && !snap_c;
  assign stat.div_done = cnt_r == 6'(ldsc_pkg::DIV_STEPS - 1);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_clock_time    = out_time_r;
  assign out_audio_start   = out_pulse_r;
  assign out_is_running    = out_run_r;
  assign out_audio_phase   = out_track_r;
  assign out_audio_elapsed = out_pos_r;

endmodule

// File: design/lead_in_drift_sync_clock_unit.sv
// Start, stop, lead-in and snap ticks (and ticks while stopped) go through prep and commit.
// Decaying ticks add, between prep and commit, a 34-step serial divider (one quotient bit
// per cycle) for dt over the halving span, then a multiply step. One item is in flight at
// a time; the result register lets the next item be taken while a result waits.
// Reset (rst_n low, synchronous) stops the clock, zeroes all time state and loads config
// defaults; there is no clearing pass.
module lead_in_drift_sync_clock_unit #(
  parameter int DECAY_TABLE_BITS = ldsc_pkg::DECAY_TABLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ldsc_in_if.sink   in_ch,
  ldsc_out_if.source out_ch,
  ldsc_cfg_if.sink  cfg_ch
);

  ldsc_pkg::ctrl_cmd_t  cmd;
  ldsc_pkg::ctrl_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ldsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ldsc_datapath #(
    .DECAY_TABLE_BITS (DECAY_TABLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_ch.command),
    .in_elapsed        (in_ch.elapsed),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_clock_time    (out_ch.clock_time),
    .out_audio_start   (out_ch.audio_start),
    .out_is_running    (out_ch.is_running),
    .out_audio_phase   (out_ch.audio_phase),
    .out_audio_elapsed (out_ch.audio_elapsed)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken twice in a row");

  a_pulse_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.audio_start |-> out_ch.audio_phase && out_ch.clock_time == 0)
    else $error("audio start without zero clock in tracking phase");

  a_pos_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.audio_phase |-> out_ch.audio_elapsed == 0)
    else $error("audio elapsed time nonzero before tracking");

  a_phase_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.audio_phase |-> out_ch.is_running)
    else $error("tracking while stopped");
`endif

endmodule
